/* hdl/mst_pkg.sv */
// shared constants, types and state codes for the mode sum tracker
package mst_pkg;

	localparam int NUM_VALUES = 1024;
	localparam int MAX_COUNT  = 1024;

	localparam int VAL_W     = 10;
	localparam int SUM_W     = 20;
	localparam int OUT_CNT_W = 11;

	localparam int CNT_W      = $clog2(MAX_COUNT + 1);
	localparam int CNT_ADDR_W = $clog2(NUM_VALUES);
	localparam int LVL_DEPTH  = MAX_COUNT / 2 + 1;
	localparam int LVL_ADDR_W = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

	localparam int CLR_LEN = (NUM_VALUES > LVL_DEPTH) ? NUM_VALUES : LVL_DEPTH;
	localparam int CLR_W   = $clog2(CLR_LEN + 1);

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CNT,
		ST_LVL
	} state_t;

	typedef struct packed {
		logic             busy;
		logic [CLR_W-1:0] idx;
	} clr_t;

	typedef struct packed {
		logic                  we_even;
		logic                  we_odd;
		logic [LVL_ADDR_W-1:0] addr_even;
		logic [LVL_ADDR_W-1:0] addr_odd;
		logic [SUM_W-1:0]      data_even;
		logic [SUM_W-1:0]      data_odd;
		logic [CNT_W-1:0]      highest;
		logic [SUM_W-1:0]      top;
	} upd_t;

endpackage

/* hdl/mst_ram.sv */
// generic single write port ram with registered read
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/mst_clear.sv */
// clearing sweep counter run once after reset
module mst_clear import mst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	output clr_t clr
);

	logic [CLR_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (idx_q != CLR_W'(CLR_LEN)) begin
			idx_q <= idx_q + CLR_W'(1);
		end
	end

	assign clr.busy = (idx_q != CLR_W'(CLR_LEN));
	assign clr.idx  = idx_q;

endmodule

/* hdl/mst_update.sv */
// level sum update and highest count tracking for one word
module mst_update import mst_pkg::*; (
	input  logic             op,
	input  logic [VAL_W-1:0] x,
	input  logic [CNT_W-1:0] c,
	input  logic [CNT_W-1:0] newc,
	input  logic [SUM_W-1:0] rd_even,
	input  logic [SUM_W-1:0] rd_odd,
	input  logic [CNT_W-1:0] highest,
	input  logic [SUM_W-1:0] top,
	input  logic [CNT_W-1:0] count0,
	output upd_t             upd
);

	logic [SUM_W-1:0] from_old;
	logic [SUM_W-1:0] to_old;
	logic [SUM_W-1:0] from_new;
	logic [SUM_W-1:0] to_new;
	logic             we_from;
	logic             we_to;
	logic             still;

	always_comb begin
		from_old = c[0] ? rd_odd : rd_even;
		to_old   = c[0] ? rd_even : rd_odd;
		from_new = from_old - SUM_W'(x);
		to_new   = (newc == '0) ? '0 : to_old + SUM_W'(x);
		we_from  = (c != '0);
		we_to    = (newc != '0);

		upd.addr_even = c[0] ? LVL_ADDR_W'(newc >> 1) : LVL_ADDR_W'(c >> 1);
		upd.addr_odd  = c[0] ? LVL_ADDR_W'(c >> 1) : LVL_ADDR_W'(newc >> 1);
		upd.data_even = c[0] ? to_new : from_new;
		upd.data_odd  = c[0] ? from_new : to_new;
		upd.we_even   = c[0] ? we_to : we_from;
		upd.we_odd    = c[0] ? we_from : we_to;

		still       = (from_new != '0) || (count0 == highest);
		upd.highest = highest;
		upd.top     = top;
		if (op == OP_ADD) begin
			if (newc >= highest) begin
				upd.highest = newc;
				upd.top     = to_new;
			end
		end else if (c == highest) begin
			if (still) begin
				upd.top = from_new;
			end else begin
				upd.highest = newc;
				upd.top     = to_new;
			end
		end
	end

endmodule

/* hdl/mode_sum_tracker.sv */
// mode sum tracker top level: sequencer, count store and level sum banks
//
// input channel: operation and value, taken when in_valid is high and
// in_stall low. output channel: mode_sum, max_count and error, one word
// per input word, taken when out_valid is high and out_stall low.
// a word reads its value count in the cycle after acceptance, then reads
// the two level sums it touches (split over even and odd level banks, so
// both are read together) and writes them back once the output
// register can take the result. a new word is taken in only while idle
// or as the previous word writes its level sums back; an ignored word
// returns to idle from its count read once the output register is free.
// after reset a clearing pass zeroes the count store and the level
// banks; in_stall stays high during it.
// a stalled output word holds in its register while the next word is
// already taken in; a finishing word waits while the output register is
// full and not being taken.
module mode_sum_tracker import mst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [VAL_W-1:0]     value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SUM_W-1:0]     mode_sum,
	output logic [OUT_CNT_W-1:0] max_count,
	output logic                 error
);

	state_t state_q;
	state_t state_d;
	clr_t   clr;
	upd_t   upd;

	logic                 in_accept;
	logic                 slot_ok;
	logic                 cnt_err;
	logic                 issue_lvl;
	logic                 commit;
	logic                 out_load_err;

	logic                 op_q;
	logic [VAL_W-1:0]     val_q;
	logic                 rng_err_q;
	logic [CNT_W-1:0]     c_q;
	logic [CNT_W-1:0]     newc_q;
	logic [CNT_W-1:0]     newc;
	logic [CNT_W-1:0]     highest_q;
	logic [SUM_W-1:0]     top_q;
	logic [CNT_W-1:0]     count0_q;

	logic                 out_valid_q;
	logic [SUM_W-1:0]     mode_sum_q;
	logic [OUT_CNT_W-1:0] max_count_q;
	logic                 error_q;

	logic [CNT_W-1:0]      cnt_rdata;
	logic [SUM_W-1:0]      even_rdata;
	logic [SUM_W-1:0]      odd_rdata;
	logic [LVL_ADDR_W-1:0] rd_addr_even;
	logic [LVL_ADDR_W-1:0] rd_addr_odd;
	logic                  clr_cnt;
	logic                  clr_lvl;

	assign slot_ok   = !out_valid_q || !out_stall;
	assign in_stall  = clr.busy || !((state_q == ST_IDLE) || ((state_q == ST_LVL) && slot_ok));
	assign in_accept = in_valid && !in_stall;

	assign clr_cnt = clr.busy && (32'(clr.idx) < NUM_VALUES);
	assign clr_lvl = clr.busy && (32'(clr.idx) < LVL_DEPTH);

	always_comb begin
		newc = (op_q == OP_ADD) ? cnt_rdata + CNT_W'(1) : cnt_rdata - CNT_W'(1);
		if (op_q == OP_ADD) begin
			cnt_err = rng_err_q || (32'(cnt_rdata) >= MAX_COUNT);
		end else begin
			cnt_err = rng_err_q || (cnt_rdata == '0) || (32'(cnt_rdata) > MAX_COUNT);
		end
		rd_addr_even = cnt_rdata[0] ? LVL_ADDR_W'(newc >> 1) : LVL_ADDR_W'(cnt_rdata >> 1);
		rd_addr_odd  = cnt_rdata[0] ? LVL_ADDR_W'(cnt_rdata >> 1) : LVL_ADDR_W'(newc >> 1);
	end

	always_comb begin
		state_d      = state_q;
		issue_lvl    = 1'b0;
		commit       = 1'b0;
		out_load_err = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				if (cnt_err) begin
					if (slot_ok) begin
						out_load_err = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					issue_lvl = 1'b1;
					state_d   = ST_LVL;
				end
			end
			ST_LVL: begin
				if (slot_ok) begin
					commit  = 1'b1;
					state_d = in_accept ? ST_CNT : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q   <= '0;
			top_q       <= '0;
			count0_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue_lvl && (val_q == '0)) begin
				count0_q <= newc;
			end
			if (commit) begin
				highest_q <= upd.highest;
				top_q     <= upd.top;
			end
			if (commit || out_load_err) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= operation;
			val_q     <= value;
			rng_err_q <= (32'(value) >= NUM_VALUES);
		end
		if (issue_lvl) begin
			c_q    <= cnt_rdata;
			newc_q <= newc;
		end
		if (commit) begin
			mode_sum_q  <= upd.top;
			max_count_q <= OUT_CNT_W'(upd.highest);
			error_q     <= 1'b0;
		end else if (out_load_err) begin
			mode_sum_q  <= top_q;
			max_count_q <= OUT_CNT_W'(highest_q);
			error_q     <= 1'b1;
		end
	end

	mst_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	mst_update u_update (
		.op      (op_q),
		.x       (val_q),
		.c       (c_q),
		.newc    (newc_q),
		.rd_even (even_rdata),
		.rd_odd  (odd_rdata),
		.highest (highest_q),
		.top     (top_q),
		.count0  (count0_q),
		.upd     (upd)
	);

	mst_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_VALUES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (clr_cnt || issue_lvl),
		.waddr (clr.busy ? CNT_ADDR_W'(clr.idx) : CNT_ADDR_W'(val_q)),
		.wdata (clr.busy ? '0 : newc),
		.re    (in_accept),
		.raddr (CNT_ADDR_W'(value)),
		.rdata (cnt_rdata)
	);

	mst_ram #(
		.WIDTH (SUM_W),
		.DEPTH (LVL_DEPTH)
	) u_even_ram (
		.clk   (clk),
		.we    (clr_lvl || (commit && upd.we_even)),
		.waddr (clr.busy ? LVL_ADDR_W'(clr.idx) : upd.addr_even),
		.wdata (clr.busy ? '0 : upd.data_even),
		.re    (issue_lvl),
		.raddr (rd_addr_even),
		.rdata (even_rdata)
	);

	mst_ram #(
		.WIDTH (SUM_W),
		.DEPTH (LVL_DEPTH)
	) u_odd_ram (
		.clk   (clk),
		.we    (clr_lvl || (commit && upd.we_odd)),
		.waddr (clr.busy ? LVL_ADDR_W'(clr.idx) : upd.addr_odd),
		.wdata (clr.busy ? '0 : upd.data_odd),
		.re    (issue_lvl),
		.raddr (rd_addr_odd),
		.rdata (odd_rdata)
	);

	assign out_valid = out_valid_q;
	assign mode_sum  = mode_sum_q;
	assign max_count = max_count_q;
	assign error     = error_q;

`ifndef SYNTHESIS
	a_zero_top: assert property (@(posedge clk) disable iff (!arst_n)
		(highest_q == '0) |-> (top_q == '0))
		else $error("level sum at top nonzero while highest count is zero");

	a_cnt_to_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CNT) && !cnt_err) |=> (state_q == ST_LVL))
		else $error("valid word did not move on to level update");

	a_err_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CNT) && cnt_err) |=> ($stable(highest_q) && $stable(top_q)))
		else $error("ignored word changed tracked maximum");
`endif

endmodule

/* verif/mode_sum_tracker_test.sv */
// testbench for the mode sum tracker: predicts every result word and compares it field by field
`timescale 1ns / 1ps

module mode_sum_tracker_test;
	import mst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [SUM_W-1:0]     sum;
		logic [OUT_CNT_W-1:0] top_count;
		logic                 ignored;
	} tracker_result_t;

	class mode_board;
		logic [OUT_CNT_W-1:0] occ [0:NUM_VALUES-1];
		logic [SUM_W-1:0]     lvl_sum [0:MAX_COUNT];
		logic [OUT_CNT_W-1:0] top;
		tracker_result_t      pending [$];
		int                   fails;

		function new();
			foreach (occ[i]) occ[i] = '0;
			foreach (lvl_sum[i]) lvl_sum[i] = '0;
			top = '0;
			fails = 0;
		endfunction

		function void note_word(logic op, logic [VAL_W-1:0] v);
			logic [OUT_CNT_W-1:0] c;
			logic                 bad;
			logic                 keep;
			tracker_result_t      r;
			bad = 1'b0;
			if (int'(v) >= NUM_VALUES) begin
				bad = 1'b1;
			end else begin
				c = occ[v];
				if (op == OP_ADD) begin
					if (int'(c) >= MAX_COUNT) begin
						bad = 1'b1;
					end else begin
						if (c != '0) lvl_sum[c] = lvl_sum[c] - SUM_W'(v);
						c = c + 1'b1;
						occ[v] = c;
						lvl_sum[c] = lvl_sum[c] + SUM_W'(v);
						if (c > top) top = c;
					end
				end else begin
					if (c == '0 || int'(c) > MAX_COUNT) begin
						bad = 1'b1;
					end else begin
						lvl_sum[c] = lvl_sum[c] - SUM_W'(v);
						c = c - 1'b1;
						occ[v] = c;
						if (c != '0) lvl_sum[c] = lvl_sum[c] + SUM_W'(v);
						if (c + 1'b1 == top) begin
							// value zero at the top level leaves no trace in the sum
							keep = (lvl_sum[top] != '0) || (occ[0] == top);
							if (!keep) top = top - 1'b1;
						end
					end
				end
			end
			r.sum = (int'(top) <= MAX_COUNT) ? lvl_sum[top] : '0;
			r.top_count = top;
			r.ignored = bad;
			pending.insert(pending.size(), r);
		endfunction

		function void check_word(logic [SUM_W-1:0] s, logic [OUT_CNT_W-1:0] c, logic e);
			tracker_result_t r;
			if (pending.size() == 0) begin
				$error("unexpected result word mode_sum %0d max_count %0d error %0d", s, c, e);
				fails++;
			end else begin
				r = pending.pop_front();
				if (s !== r.sum) begin
					$error("mode_sum expected %0d actual %0d", r.sum, s);
					fails++;
				end
				if (c !== r.top_count) begin
					$error("max_count expected %0d actual %0d", r.top_count, c);
					fails++;
				end
				if (e !== r.ignored) begin
					$error("error expected %0d actual %0d", r.ignored, e);
					fails++;
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 operation;
	logic [VAL_W-1:0]     value;
	logic                 out_valid;
	logic                 out_stall;
	logic [SUM_W-1:0]     mode_sum;
	logic [OUT_CNT_W-1:0] max_count;
	logic                 error;

	mode_board board = new();
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_off = 0;
	int  cycle_count = 0;

	mode_sum_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode_sum(mode_sum),
		.max_count(max_count),
		.error(error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// result side: stall decided at the edge, word taken when seen unstalled mid-cycle
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= hold_off || ($urandom_range(99) < stall_pct);
			@(negedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_word(mode_sum, max_count, error);
		end
	end

	task automatic send_word(logic op, logic [VAL_W-1:0] v);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		board.note_word(op, v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(int n_items, int idle_p, int stall_p);
		logic [VAL_W-1:0] pool [6];
		logic [VAL_W-1:0] v;
		logic             op;
		int               add_pct;
		send_idle_pct = idle_p;
		stall_pct = stall_p;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < 6; i++) pool[i] = VAL_W'($urandom_range(NUM_VALUES - 1));
		for (int i = 0; i < n_items; i++) begin
			// build counts up first, then drain them so the top level falls
			add_pct = (i < n_items / 2) ? 70 : 35;
			op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_REMOVE;
			if ($urandom_range(99) < 20)
				v = VAL_W'($urandom_range(NUM_VALUES - 1));
			else
				v = pool[$urandom_range(5)];
			send_word(op, v);
		end
		drain();
	endtask

	initial begin
		logic [VAL_W-1:0] sat_val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		value = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_REMOVE, '0);
		send_word(OP_REMOVE, '1);
		send_word(OP_ADD, '0);
		send_word(OP_ADD, '0);
		send_word(OP_REMOVE, '0);
		send_word(OP_ADD, '1);
		send_word(OP_ADD, '1);
		send_word(OP_ADD, '0);
		send_word(OP_REMOVE, '1);
		send_word(OP_ADD, 10'h155);
		send_word(OP_ADD, 10'h2AA);
		send_word(OP_ADD, 10'h2AA);
		send_word(OP_ADD, 10'h2AA);
		send_word(OP_ADD, 10'h200);
		send_word(OP_REMOVE, 10'h2AA);
		send_word(OP_REMOVE, 10'h155);
		send_word(OP_REMOVE, 10'h155);
		send_word(OP_REMOVE, '0);
		send_word(OP_REMOVE, '0);
		send_word(OP_REMOVE, '0);
		send_word(OP_REMOVE, '1);
		send_word(OP_ADD, 10'h001);
		drain();

		random_phase(200, 0, 0);
		random_phase(200, 84, 0);
		random_phase(200, 0, 84);
		random_phase(200, 16, 16);

		// long hold-off on the result side while words keep coming
		fork
			begin
				@(negedge clk);
				hold_off = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		random_phase(100, 0, 0);

		// push one value up to the count limit and past it
		send_idle_pct = 16;
		stall_pct = 16;
		sat_val = VAL_W'($urandom_range(NUM_VALUES - 1));
		for (int i = 0; i < MAX_COUNT + 2; i++) send_word(OP_ADD, sat_val);
		send_word(OP_ADD, '0);
		send_word(OP_REMOVE, sat_val);
		send_word(OP_REMOVE, sat_val);
		send_word(OP_ADD, sat_val);
		drain();
		repeat (10) @(posedge clk);

		if (board.fails == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
